FILE: hw/rtl/mses_pkg.sv
// Shared types and constants for the MIPS subset execute step unit.
// Holds opcode and function codes, decoded item kinds and the decoded item struct.
// Depends on nothing; the front end, queue, back end and top level import it.
package mses_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = 5;
   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] PC_RESET_VALUE = 32'h0040_0000;
   localparam logic [WORD_W-1:0] PC_STEP = 32'd4;
   localparam logic [REG_IDX_W-1:0] RA_INDEX = 5'd31;

   localparam logic [5:0] OPC_SPECIAL = 6'h00;
   localparam logic [5:0] OPC_JAL = 6'h03;
   localparam logic [5:0] OPC_BNE = 6'h05;
   localparam logic [5:0] OPC_BLEZ = 6'h06;
   localparam logic [5:0] OPC_ADDI = 6'h08;
   localparam logic [5:0] OPC_ANDI = 6'h0C;

   localparam logic [5:0] FN_SLL = 6'h00;
   localparam logic [5:0] FN_SRL = 6'h02;
   localparam logic [5:0] FN_JR = 6'h08;
   localparam logic [5:0] FN_ADD = 6'h20;

   localparam logic [3:0] KIND_ADDI = 4'd0;
   localparam logic [3:0] KIND_ANDI = 4'd1;
   localparam logic [3:0] KIND_BLEZ = 4'd2;
   localparam logic [3:0] KIND_BNE = 4'd3;
   localparam logic [3:0] KIND_JAL = 4'd4;
   localparam logic [3:0] KIND_ADD = 4'd5;
   localparam logic [3:0] KIND_SLL = 4'd6;
   localparam logic [3:0] KIND_SRL = 4'd7;
   localparam logic [3:0] KIND_JR = 4'd8;
   localparam logic [3:0] KIND_ILLEGAL = 4'd9;

   typedef struct packed {
      logic [3:0]           kind;
      logic                 wr;
      logic [REG_IDX_W-1:0] rs;
      logic [REG_IDX_W-1:0] rt;
      logic [REG_IDX_W-1:0] dst;
      logic [WORD_W-1:0]    imm;
      logic [4:0]           shamt;
      logic [25:0]          target;
   } decode_type;

endpackage

FILE: hw/rtl/mses_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module mses_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // A read in the same cycle as a write to that address returns the old data.
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

FILE: hw/rtl/mses_front.sv
// Front end: classifies one instruction word into a decoded item.
// Depends on mses_pkg.
module mses_front
   import mses_pkg::*;
(
   input  logic [WORD_W-1:0] instr_word,
   output decode_type        item
);

   logic [5:0]           opcode;
   logic [5:0]           funct;
   logic                 writes;
   logic [REG_IDX_W-1:0] dst_raw;

   assign opcode = instr_word[31:26];
   assign funct = instr_word[5:0];

   always_comb begin
      item = '0;
      item.rs = instr_word[25:21];
      item.rt = instr_word[20:16];
      item.shamt = instr_word[10:6];
      item.target = instr_word[25:0];
      item.imm = {{16{instr_word[15]}}, instr_word[15:0]};
      writes = 1'b0;
      dst_raw = '0;
      unique case (opcode)
         OPC_ADDI: begin
            item.kind = KIND_ADDI;
            writes = 1'b1;
            dst_raw = instr_word[20:16];
         end
         OPC_ANDI: begin
            item.kind = KIND_ANDI;
            item.imm = {16'h0000, instr_word[15:0]};
            writes = 1'b1;
            dst_raw = instr_word[20:16];
         end
         OPC_BLEZ: item.kind = KIND_BLEZ;
         OPC_BNE: item.kind = KIND_BNE;
         OPC_JAL: begin
            item.kind = KIND_JAL;
            writes = 1'b1;
            dst_raw = RA_INDEX;
         end
         OPC_SPECIAL: begin
            unique case (funct)
               FN_ADD: begin
                  item.kind = KIND_ADD;
                  writes = 1'b1;
                  dst_raw = instr_word[15:11];
               end
               FN_SLL: begin
                  item.kind = KIND_SLL;
                  writes = 1'b1;
                  dst_raw = instr_word[15:11];
               end
               FN_SRL: begin
                  item.kind = KIND_SRL;
                  writes = 1'b1;
                  dst_raw = instr_word[15:11];
               end
               FN_JR: item.kind = KIND_JR;
               default: item.kind = KIND_ILLEGAL;
            endcase
         end
         default: item.kind = KIND_ILLEGAL;
      endcase
      // Writes to register zero are dropped here, so the back end never sees them.
      item.wr = writes && (dst_raw != '0);
      item.dst = item.wr ? dst_raw : '0;
   end

endmodule

FILE: hw/rtl/mses_queue.sv
// Short FIFO of decoded items between the front end and the back end.
// Depends on mses_pkg. DEPTH must be a power of two, at least 2.
module mses_queue
   import mses_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  decode_type push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output decode_type pop_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   decode_type    slot_ff [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = slot_ff[rptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wptr_in = push ? wptr_ff + AW'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + AW'(1) : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/mses_back.sv
// Back end: reads operands, executes the decoded item, updates registers and pc.
// Depends on mses_pkg and mses_ram; drives the response output register.
module mses_back
   import mses_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   output logic              head_ready,
   input  decode_type        head_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_next_pc,
   output logic              rsp_reg_written,
   output logic [4:0]        rsp_dest_index,
   output logic [WORD_W-1:0] rsp_dest_value,
   output logic              rsp_branch_taken,
   output logic              rsp_illegal_instr
);

   logic                 e_valid_ff, e_valid_in;
   decode_type           e_item_ff;
   logic                 fwd_s_ff, fwd_t_ff;
   logic                 vld_s_ff, vld_t_ff;
   logic [WORD_W-1:0]    fwd_val_ff;
   logic [REG_COUNT-1:0] reg_vld_ff, reg_vld_in;
   logic [WORD_W-1:0]    pc_ff, pc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_next_pc_ff;
   logic                 rsp_reg_written_ff;
   logic [4:0]           rsp_dest_index_ff;
   logic [WORD_W-1:0]    rsp_dest_value_ff;
   logic                 rsp_branch_taken_ff;
   logic                 rsp_illegal_instr_ff;

   logic                 e_fire, launch;
   logic                 wr_en;
   logic [WORD_W-1:0]    rd_a, rd_b;
   logic [WORD_W-1:0]    vs, vt;
   logic [WORD_W-1:0]    seq_pc, br_target, npc, result;
   logic                 taken, illegal;

   assign e_fire = e_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign head_ready = !e_valid_ff || e_fire;
   assign launch = head_valid && head_ready;
   assign wr_en = e_fire && e_item_ff.wr;

   mses_ram #(
      .WIDTH (WORD_W),
      .DEPTH (REG_COUNT)
   ) u_regs (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (e_item_ff.dst),
      .wr_data   (result),
      .rd_en     (launch),
      .rd_addr_a (head_data.rs),
      .rd_addr_b (head_data.rt),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // A register never written since reset reads as zero; a write retiring in the
   // cycle an operand is read is forwarded, since the memory returns the old value.
   assign vs = fwd_s_ff ? fwd_val_ff : (vld_s_ff ? rd_a : '0);
   assign vt = fwd_t_ff ? fwd_val_ff : (vld_t_ff ? rd_b : '0);

   assign seq_pc = pc_ff + PC_STEP;
   assign br_target = seq_pc + {e_item_ff.imm[WORD_W-3:0], 2'b00};

   always_comb begin
      result = '0;
      npc = seq_pc;
      taken = 1'b0;
      illegal = 1'b0;
      unique case (e_item_ff.kind)
         KIND_ADDI: result = vs + e_item_ff.imm;
         KIND_ANDI: result = vs & e_item_ff.imm;
         KIND_BLEZ: begin
            if ((vs == '0) || vs[WORD_W-1]) begin
               taken = 1'b1;
               npc = br_target;
            end
         end
         KIND_BNE: begin
            if (vs != vt) begin
               taken = 1'b1;
               npc = br_target;
            end
         end
         KIND_JAL: begin
            result = seq_pc;
            taken = 1'b1;
            npc = {seq_pc[31:28], e_item_ff.target, 2'b00};
         end
         KIND_ADD: result = vs + vt;
         KIND_SLL: result = vt << e_item_ff.shamt;
         KIND_SRL: result = vt >> e_item_ff.shamt;
         KIND_JR: begin
            taken = 1'b1;
            npc = vs;
         end
         default: illegal = 1'b1;
      endcase
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      if (launch) begin
         e_valid_in = 1'b1;
      end else if (e_fire) begin
         e_valid_in = 1'b0;
      end
      reg_vld_in = reg_vld_ff;
      if (wr_en) begin
         reg_vld_in = reg_vld_ff | (REG_COUNT'(1) << e_item_ff.dst);
      end
      pc_in = e_fire ? npc : pc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (e_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         reg_vld_ff <= '0;
         pc_ff <= PC_RESET_VALUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
         reg_vld_ff <= reg_vld_in;
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (launch) begin
         e_item_ff <= head_data;
         fwd_s_ff <= wr_en && (e_item_ff.dst == head_data.rs);
         fwd_t_ff <= wr_en && (e_item_ff.dst == head_data.rt);
         fwd_val_ff <= result;
         vld_s_ff <= reg_vld_ff[head_data.rs];
         vld_t_ff <= reg_vld_ff[head_data.rt];
      end
      if (e_fire) begin
         rsp_next_pc_ff <= npc;
         rsp_reg_written_ff <= e_item_ff.wr;
         rsp_dest_index_ff <= e_item_ff.dst;
         rsp_dest_value_ff <= e_item_ff.wr ? result : '0;
         rsp_branch_taken_ff <= taken;
         rsp_illegal_instr_ff <= illegal;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_pc = rsp_next_pc_ff;
   assign rsp_reg_written = rsp_reg_written_ff;
   assign rsp_dest_index = rsp_dest_index_ff;
   assign rsp_dest_value = rsp_dest_value_ff;
   assign rsp_branch_taken = rsp_branch_taken_ff;
   assign rsp_illegal_instr = rsp_illegal_instr_ff;

endmodule

FILE: hw/rtl/mips_subset_execute_step_unit.sv
// Sustained rate is one instruction per clock while rsp_ready stays high: a request
// accepted by the queue is decoded into a queue slot, launched from there into the
// execute stage (two-port register file read), and its response is then registered in
// the response output register. Reset needs no clearing pass; per-register valid bits
// make unwritten registers read as zero. The pc starts at 0x00400000.
// Top level: instantiates mses_front, mses_queue and mses_back; depends on mses_pkg.
module mips_subset_execute_step_unit
   import mses_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_branch_taken,
   output logic        rsp_illegal_instr
);

   decode_type front_item;
   decode_type head_item;
   logic       head_valid;
   logic       head_ready;

   mses_front u_front (
      .instr_word (req_instr_word),
      .item       (front_item)
   );

   mses_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_item),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_data   (head_item)
   );

   mses_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_ready        (head_ready),
      .head_data         (head_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_reg_written   (rsp_reg_written),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_dest_value    (rsp_dest_value),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_illegal_instr (rsp_illegal_instr)
   );

endmodule

FILE: hw/rtl/mses_checker.sv
// Port-level checker for the execute step unit, bound to the top level.
// Depends only on the top level's port names.
module mses_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_next_pc,
   input logic        rsp_reg_written,
   input logic [4:0]  rsp_dest_index,
   input logic [31:0] rsp_dest_value,
   input logic        rsp_branch_taken,
   input logic        rsp_illegal_instr
);

   // Register zero is never reported as written.
   a_write_not_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_written |-> rsp_dest_index != 5'd0)
      else $error("response writes register zero");

   a_quiet_without_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_written |-> rsp_dest_index == 5'd0 && rsp_dest_value == 32'd0)
      else $error("destination fields set without a register write");

   // An unsupported instruction behaves as a no-op.
   a_illegal_is_nop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal_instr |-> !rsp_reg_written && !rsp_branch_taken)
      else $error("illegal instruction wrote a register or changed control flow");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc)
         && $stable(rsp_dest_value))
      else $error("stalled response changed");

endmodule

bind mips_subset_execute_step_unit mses_checker u_checker (.*);
